// ===== rtl/core/gelu_activation_unit_macros.svh =====
// assertion macros shared by the gelu activation unit rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GELU_ACTIVATION_UNIT_MACROS_SVH
`define GELU_ACTIVATION_UNIT_MACROS_SVH

// same-cycle implication
`define GAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gelu unit check failed");

// next-cycle implication
`define GAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gelu unit check failed");

`endif

// ===== rtl/core/gau_pkg.sv =====
// gau_pkg: widths, fixed-point constants and stage indices of the gelu pipeline
// no dependencies; used by gau_datapath and gelu_activation_unit
`timescale 1ns / 1ps

package gau_pkg;

  // sample width and quotient width
  localparam int AW      = 16;
  localparam int QW      = 16;

  // datapath widths
  localparam int SQ_W    = 32;
  localparam int CUBE_PW = 48;
  localparam int CUBE_W  = 46;
  localparam int HALF_W  = 23;
  localparam int PP_W    = 39;
  localparam int VS_W    = 62;
  localparam int V_W     = 29;
  localparam int S_W     = 30;
  localparam int US_W    = 54;
  localparam int U_W     = 30;
  localparam int Z_W     = 31;
  localparam int R_W     = 28;
  localparam int T_W     = 31;
  localparam int P_W     = 28;
  localparam int MP_W    = 60;
  localparam int TP_W    = 59;
  localparam int SQP_W   = 62;
  localparam int D_W     = 32;
  localparam int AE_W    = 47;
  localparam int NUM_W   = 47;
  localparam int SQN     = 6;

  // coefficients and rounding terms
  localparam logic [15:0]       C1     = 16'd46887;
  localparam logic [23:0]       C0     = 24'd13386282;
  localparam logic [T_W-1:0]    ONE    = T_W'(1) << 30;
  localparam logic [Z_W-1:0]    ZLIM   = Z_W'(12) << 24;
  localparam logic [31:0]       M5     = 32'hCCCC_CCCD;
  localparam logic [31:0]       M3     = 32'hAAAA_AAAB;
  localparam logic [VS_W-1:0]   V_RND  = VS_W'(1) << 31;
  localparam logic [US_W-1:0]   U_RND  = US_W'(1) << 23;
  localparam logic [SQP_W-1:0]  SQ_RND = SQP_W'(1) << 29;
  localparam logic [AW-1:0]     Y_MAX  = 16'h7FFF;

  // stage indices
  localparam int S_A   = 0;
  localparam int S_SQ  = 1;
  localparam int S_V   = 4;
  localparam int S_Z   = 7;
  localparam int S_T5  = 9;
  localparam int S_T4  = 11;
  localparam int S_T3  = 14;
  localparam int S_T2  = 16;
  localparam int S_P1  = 17;
  localparam int S_E   = S_P1 + 2 + 2 * SQN;
  localparam int S_AE  = S_E + 1;
  localparam int S_NUM = S_AE + 1;
  localparam int S_OUT = S_NUM + QW + 1;

  typedef struct packed {
    logic en;
    logic vld;
  } gau_ctl_t;

endpackage

// ===== rtl/core/gau_datapath.sv =====
// gau_datapath: stall-enabled gelu pipeline, cube, polynomial, exp series,
// repeated squaring and a one-bit-per-stage divider; depends on gau_pkg
`timescale 1ns / 1ps
`include "gelu_activation_unit_macros.svh"

module gau_datapath import gau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gau_ctl_t             ctl_i,
  input  logic signed [AW-1:0] x_i,
  output logic                 vld_o,
  output logic signed [AW-1:0] y_o
);

  logic [AW-1:0]      x_raw;
  logic [AW-1:0]      a_in;
  logic [CUBE_PW-1:0] cube_full;
  logic [VS_W-1:0]    vsum;
  logic [S_W-1:0]     s_d;
  logic [US_W-1:0]    us_d;
  logic [US_W-1:0]    us_rnd;
  logic [Z_W-1:0]     z_d;
  logic [MP_W-1:0]    q5_full;
  logic [MP_W-1:0]    q3_full;
  logic [TP_W-1:0]    p4_full;
  logic [TP_W-1:0]    p3_full;
  logic [TP_W-1:0]    p2_full;
  logic [TP_W-1:0]    p1_full;
  logic [T_W-1:0]     e_d;
  logic [D_W-1:0]     d_d;
  logic [NUM_W-1:0]   num_d;
  logic [SQP_W-1:0]   sq_rnd [SQN];
  logic [NUM_W:0]     dv_diff [QW];
  logic [QW-1:0]      m_d;
  logic [AW-1:0]      y_d;

  logic [S_OUT:0]      vld_q;
  logic [AW-1:0]       a_q   [S_A:S_NUM-1];
  logic                neg_q [S_A:S_OUT];
  logic [SQ_W-1:0]     sq_q;
  logic [CUBE_W-1:0]   cube_q;
  logic [PP_W-1:0]     plo_q;
  logic [PP_W-1:0]     phi_q;
  logic [V_W-1:0]      v_q;
  logic [S_W-1:0]      s_q;
  logic [US_W-1:0]     us_q;
  logic [R_W-1:0]      r_q   [S_Z:S_P1-1];
  logic                sat_q [S_Z:S_E-1];
  logic [P_W-1:0]      q5_q;
  logic [T_W-1:0]      t5_q;
  logic [P_W-1:0]      p4_q;
  logic [T_W-1:0]      t4_q;
  logic [P_W-1:0]      p3_q;
  logic [P_W-1:0]      q3_q;
  logic [T_W-1:0]      t3_q;
  logic [P_W-1:0]      p2_q;
  logic [T_W-1:0]      t2_q;
  logic [P_W-1:0]      p1_q;
  logic [T_W-1:0]      sqt_q [0:SQN];
  logic [SQP_W-1:0]    sqp_q [SQN];
  logic [T_W-1:0]      e_q;
  logic [D_W-1:0]      d_q   [S_E:S_OUT-1];
  logic [AE_W-1:0]     ae_q;
  logic [NUM_W-1:0]    rem_q [S_NUM:S_OUT-1];
  logic [QW-1:0]       quo_q [S_NUM:S_OUT-1];
  logic signed [AW-1:0] y_q;

  assign x_raw = unsigned'(x_i);

  always_comb begin
    a_in      = x_raw[AW-1] ? (AW'(0) - x_raw) : x_raw;
    cube_full = CUBE_PW'(sq_q) * CUBE_PW'(a_q[S_SQ]);
    vsum      = {phi_q, {HALF_W{1'b0}}} + VS_W'(plo_q) + V_RND;
    s_d       = (S_W'(a_q[S_V]) << 12) + S_W'(v_q);
    us_d      = US_W'(s_q) * US_W'(C0);
    us_rnd    = us_q + U_RND;
    z_d       = {us_rnd[24 +: U_W], 1'b0};
    // exp(-r) series, horner form, divisions by 5 and 3 via reciprocal
    q5_full   = MP_W'(r_q[S_Z]) * MP_W'(M5);
    p4_full   = TP_W'(r_q[S_T5]) * TP_W'(t5_q);
    p3_full   = TP_W'(r_q[S_T4]) * TP_W'(t4_q);
    q3_full   = MP_W'(p3_q) * MP_W'(M3);
    p2_full   = TP_W'(r_q[S_T3]) * TP_W'(t3_q);
    p1_full   = TP_W'(r_q[S_T2]) * TP_W'(t2_q);
    for (int j = 0; j < SQN; j++) begin
      sq_rnd[j] = sqp_q[j] + SQ_RND;
    end
    e_d   = sat_q[S_E-1] ? '0 : sqt_q[SQN];
    d_d   = D_W'(ONE) + D_W'(e_d);
    num_d = (neg_q[S_AE] ? ae_q : (NUM_W'(a_q[S_AE]) << 30)) + NUM_W'(d_q[S_AE] >> 1);
    // restoring divide, one quotient bit per stage
    for (int j = 0; j < QW; j++) begin
      dv_diff[j] = {1'b0, rem_q[S_NUM+j]} - {1'b0, (NUM_W'(d_q[S_NUM+j]) << (QW - 1 - j))};
    end
    m_d = quo_q[S_OUT-1];
    y_d = neg_q[S_OUT-1] ? (AW'(0) - m_d) : (m_d[AW-1] ? Y_MAX : m_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[S_OUT-1:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      a_q[S_A]   <= a_in;
      neg_q[S_A] <= x_raw[AW-1];
      for (int i = S_A + 1; i < S_NUM; i++) begin
        a_q[i] <= a_q[i-1];
      end
      for (int i = S_A + 1; i <= S_OUT; i++) begin
        neg_q[i] <= neg_q[i-1];
      end
      sq_q   <= SQ_W'(a_q[S_A]) * SQ_W'(a_q[S_A]);
      cube_q <= cube_full[CUBE_W-1:0];
      plo_q  <= PP_W'(cube_q[HALF_W-1:0]) * PP_W'(C1);
      phi_q  <= PP_W'(cube_q[CUBE_W-1:HALF_W]) * PP_W'(C1);
      v_q    <= vsum[32 +: V_W];
      s_q    <= s_d;
      us_q   <= us_d;
      r_q[S_Z]   <= z_d[R_W-1:0];
      sat_q[S_Z] <= (z_d >= ZLIM);
      for (int i = S_Z + 1; i < S_P1; i++) begin
        r_q[i] <= r_q[i-1];
      end
      for (int i = S_Z + 1; i < S_E; i++) begin
        sat_q[i] <= sat_q[i-1];
      end
      q5_q <= P_W'(q5_full[MP_W-1:34]);
      t5_q <= ONE - T_W'(q5_q);
      p4_q <= p4_full[30 +: P_W];
      t4_q <= ONE - T_W'(p4_q >> 2);
      p3_q <= p3_full[30 +: P_W];
      q3_q <= P_W'(q3_full[MP_W-1:33]);
      t3_q <= ONE - T_W'(q3_q);
      p2_q <= p2_full[30 +: P_W];
      t2_q <= ONE - T_W'(p2_q >> 1);
      p1_q <= p1_full[30 +: P_W];
      sqt_q[0] <= ONE - T_W'(p1_q);
      for (int j = 0; j < SQN; j++) begin
        sqp_q[j]   <= SQP_W'(sqt_q[j]) * SQP_W'(sqt_q[j]);
        sqt_q[j+1] <= sq_rnd[j][30 +: T_W];
      end
      e_q      <= e_d;
      d_q[S_E] <= d_d;
      for (int i = S_E + 1; i < S_OUT; i++) begin
        d_q[i] <= d_q[i-1];
      end
      ae_q <= AE_W'(a_q[S_E]) * AE_W'(e_q);
      rem_q[S_NUM] <= num_d;
      quo_q[S_NUM] <= '0;
      for (int j = 0; j < QW; j++) begin
        rem_q[S_NUM+1+j] <= dv_diff[j][NUM_W] ? rem_q[S_NUM+j] : dv_diff[j][NUM_W-1:0];
        quo_q[S_NUM+1+j] <= {quo_q[S_NUM+j][QW-2:0], ~dv_diff[j][NUM_W]};
      end
      y_q <= signed'(y_d);
    end
  end

  assign vld_o = vld_q[S_OUT];
  assign y_o   = y_q;

  `GAU_ASSERT_NEXT(a_stall_freezes, !ctl_i.en, $stable(vld_q))
  `GAU_ASSERT_NOW(a_exp_bounded, vld_q[S_E], e_q <= ONE)
  `GAU_ASSERT_NOW(a_div_rem, vld_q[S_OUT-1], rem_q[S_OUT-1] < NUM_W'(d_q[S_OUT-1]))
  `GAU_ASSERT_NOW(a_pos_sign, vld_q[S_OUT] && !neg_q[S_OUT], !y_q[AW-1])

endmodule

// ===== rtl/core/gelu_activation_unit.sv =====
// gelu_activation_unit: top level, input skid register and pipeline enable
// depends on gau_pkg and gau_datapath
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+------------------
//   input   | in_valid_i  | in_ready_o  | x_in_i  (Q4.12)
//   output  | out_valid_o | out_ready_i | y_out_o (Q4.12)
//
// one request per cycle sustained while no held result stalls the pipeline
// the datapath has 51 register stages, every stage advances together
// reset clears the valid bits and the skid valid flag, no payload is reset
// a held result freezes the pipeline; one request arriving then waits in
// the skid register and in_ready_o drops until it has entered
`timescale 1ns / 1ps
`include "gelu_activation_unit_macros.svh"

module gelu_activation_unit import gau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [AW-1:0] x_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [AW-1:0] y_out_o
);

  logic                 skid_vld_q;
  logic signed [AW-1:0] skid_q;
  logic                 pipe_en;
  logic                 dp_vld;
  gau_ctl_t             ctl;
  logic signed [AW-1:0] dp_x;

  assign pipe_en    = !dp_vld || out_ready_i;
  assign in_ready_o = !skid_vld_q;
  assign ctl.en     = pipe_en;
  assign ctl.vld    = skid_vld_q || in_valid_i;
  assign dp_x       = skid_vld_q ? skid_q : x_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (pipe_en) begin
      skid_vld_q <= 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pipe_en && in_valid_i && !skid_vld_q) begin
      skid_q <= x_in_i;
    end
  end

  gau_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (dp_x),
    .vld_o  (dp_vld),
    .y_o    (y_out_o)
  );

  assign out_valid_o = dp_vld;

  `GAU_ASSERT_NEXT(a_skid_hold, skid_vld_q && !pipe_en, skid_vld_q)
  `GAU_ASSERT_NEXT(a_skid_fill, in_valid_i && in_ready_o && !pipe_en, skid_vld_q && (skid_q == $past(x_in_i)))
  `GAU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(y_out_o))

endmodule
